>>> hdl/rc5hb_pkg.sv
// ----------------------------------------------------------------------------
// rc5hb_pkg
// Shared types and constants of the RC5 half-bit frame decoder.
// ----------------------------------------------------------------------------
package rc5hb_pkg;

    localparam int DURATION_W = 16;
    localparam int TOL_W      = 7;
    localparam int HALF_W     = 5;
    localparam int PAIR_W     = 4;
    localparam int CMD_W      = 6;

    localparam logic [HALF_W-1:0] HALVES_PER_FRAME = 5'd28;
    localparam logic [HALF_W-1:0] START_HALVES     = 5'd4;
    localparam logic [PAIR_W-1:0] TOGGLE_PAIR      = 4'd2;
    localparam logic [PAIR_W-1:0] FIRST_CMD_PAIR   = 4'd8;
    localparam logic [TOL_W-1:0]  TOLERANCE_RESET  = 7'd40;
    localparam logic [TOL_W-1:0]  PCT_SCALE        = 7'd100;

    typedef struct packed {
        logic                  is_mark;
        logic [DURATION_W-1:0] duration_us;
        logic                  end_of_capture;
    } pulse_t;

    typedef struct packed {
        logic             frame_ok;
        logic [CMD_W-1:0] command;
        logic             toggle;
    } result_t;

endpackage

>>> hdl/rc5hb_pulse_if.sv
// ----------------------------------------------------------------------------
// rc5hb_pulse_if
// Pulse channel: one word per received pulse, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rc5hb_pulse_if;
    import rc5hb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  is_mark;
    logic [DURATION_W-1:0] duration_us;
    logic                  end_of_capture;

    modport source (output valid, output is_mark, output duration_us,
                    output end_of_capture, input ready);
    modport sink   (input valid, input is_mark, input duration_us,
                    input end_of_capture, output ready);
endinterface

>>> hdl/rc5hb_frame_if.sv
// ----------------------------------------------------------------------------
// rc5hb_frame_if
// Frame result channel: one word per closed capture, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rc5hb_frame_if;
    import rc5hb_pkg::*;

    logic             valid;
    logic             ready;
    logic             frame_ok;
    logic [CMD_W-1:0] command;
    logic             toggle;

    modport source (output valid, output frame_ok, output command, output toggle,
                    input ready);
    modport sink   (input valid, input frame_ok, input command, input toggle,
                    output ready);
endinterface

>>> hdl/rc5hb_cfg_if.sv
// ----------------------------------------------------------------------------
// rc5hb_cfg_if
// Configuration write channel carrying the tolerance register value.
// ----------------------------------------------------------------------------
interface rc5hb_cfg_if;
    import rc5hb_pkg::*;

    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] tolerance_pct;

    modport source (output valid, output tolerance_pct, input ready);
    modport sink   (input valid, input tolerance_pct, output ready);
endinterface

>>> hdl/rc5hb_pulse_stage.sv
// ----------------------------------------------------------------------------
// rc5hb_pulse_stage
// Input register holding one accepted pulse word for the decode stage.
// ----------------------------------------------------------------------------
module rc5hb_pulse_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rc5hb_pkg::pulse_t in_pulse,
    input  logic              take,
    output logic              stage_valid,
    output rc5hb_pkg::pulse_t stage_pulse
);
    import rc5hb_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    pulse_t pulse_reg;

    // Stage refills in the same cycle it is drained.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pulse_reg <= in_pulse;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_pulse = pulse_reg;
endmodule

>>> hdl/rc5hb_decode.sv
// ----------------------------------------------------------------------------
// rc5hb_decode
// Frame state and single-pass half-bit checks; emits a result on end of capture.
// ----------------------------------------------------------------------------
module rc5hb_decode
#(
    parameter int DURATION_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           stage_valid,
    input  rc5hb_pkg::pulse_t              stage_pulse,
    input  logic [rc5hb_pkg::TOL_W-1:0]    tolerance,
    input  logic                           slot_free,
    output logic                           take,
    output logic                           res_valid,
    output rc5hb_pkg::result_t             result
);
    import rc5hb_pkg::*;

    localparam int RefW  = (DURATION_BITS < DURATION_W) ? DURATION_BITS : DURATION_W;
    localparam int ProdW = RefW + TOL_W;
    localparam logic [DURATION_W:0] SatMax =
        (DURATION_BITS >= DURATION_W) ? {1'b0, {DURATION_W{1'b1}}}
                                      : ((DURATION_W+1)'(1) << DURATION_BITS) - 1'b1;

    logic [HALF_W-1:0] half_reg, half_next;
    logic [RefW-1:0]   ref_reg, ref_next;
    logic              first_mark_reg, first_mark_next;
    logic              failed_reg, failed_next;
    logic              toggle_reg, toggle_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;

    logic [RefW-1:0]   dur;
    logic [RefW-1:0]   ref_eff;
    logic [RefW-1:0]   diff;
    logic [ProdW-1:0]  lhs;
    logic [ProdW-1:0]  rhs;
    logic              in_frame;
    logic              level_bad;
    logic [PAIR_W-1:0] pair;
    logic              bit_val;
    logic              eoc;

    // End-of-capture words wait for room in the result register.
    assign eoc  = stage_pulse.end_of_capture;
    assign take = stage_valid && (!eoc || slot_free);

    always_comb
    begin
        if ({1'b0, stage_pulse.duration_us} > SatMax)
            dur = RefW'(SatMax);
        else
            dur = RefW'(stage_pulse.duration_us);

        in_frame = half_reg < HALVES_PER_FRAME;
        ref_eff  = (half_reg == '0) ? dur : ref_reg;
        diff     = (dur >= ref_eff) ? (dur - ref_eff) : (ref_eff - dur);
        lhs      = ProdW'(diff) * ProdW'(PCT_SCALE);
        rhs      = ProdW'(ref_eff) * ProdW'(tolerance);
        // Start bits: even halves mark, odd halves space.
        level_bad = (half_reg < START_HALVES) && (stage_pulse.is_mark == half_reg[0]);
        pair      = half_reg[HALF_W-1:1];
        bit_val   = first_mark_reg && !stage_pulse.is_mark;

        half_next       = half_reg;
        ref_next        = ref_reg;
        first_mark_next = first_mark_reg;
        failed_next     = failed_reg;
        toggle_next     = toggle_reg;
        cmd_next        = cmd_reg;

        if (in_frame)
        begin
            half_next = half_reg + 1'b1;
            ref_next  = ref_eff;
            if ((lhs > rhs) || level_bad)
                failed_next = 1'b1;
            if (!half_reg[0])
                first_mark_next = stage_pulse.is_mark;
            else if (pair == TOGGLE_PAIR)
                toggle_next = bit_val;
            else if (pair >= FIRST_CMD_PAIR)
                cmd_next = {cmd_reg[CMD_W-2:0], bit_val};
        end

        result.frame_ok = !failed_next && (half_next >= HALVES_PER_FRAME);
        result.command  = result.frame_ok ? cmd_next : '0;
        result.toggle   = result.frame_ok && toggle_next;
        res_valid       = take && eoc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg       <= '0;
            ref_reg        <= '0;
            first_mark_reg <= 1'b0;
            failed_reg     <= 1'b0;
            toggle_reg     <= 1'b0;
            cmd_reg        <= '0;
        end
        else if (take)
        begin
            if (eoc)
            begin
                half_reg       <= '0;
                ref_reg        <= '0;
                first_mark_reg <= 1'b0;
                failed_reg     <= 1'b0;
                toggle_reg     <= 1'b0;
                cmd_reg        <= '0;
            end
            else
            begin
                half_reg       <= half_next;
                ref_reg        <= ref_next;
                first_mark_reg <= first_mark_next;
                failed_reg     <= failed_next;
                toggle_reg     <= toggle_next;
                cmd_reg        <= cmd_next;
            end
        end
    end
endmodule

>>> hdl/rc5hb_result_reg.sv
// ----------------------------------------------------------------------------
// rc5hb_result_reg
// Output register holding one frame result word until the sink takes it.
// ----------------------------------------------------------------------------
module rc5hb_result_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  rc5hb_pkg::result_t result,
    output logic               slot_free,
    output logic               out_valid,
    input  logic               out_ready,
    output rc5hb_pkg::result_t out_result
);
    import rc5hb_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign slot_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
endmodule

>>> hdl/rc5_half_bit_frame_decoder.sv
// ----------------------------------------------------------------------------
// rc5_half_bit_frame_decoder
// RC5 infrared frame decoder working on half-bit pulses of one capture.
// ----------------------------------------------------------------------------
// Usage:
//   pulse : one word per received pulse (level, duration in us, end flag).
//           The first pulse of a capture sets the half-bit reference; the
//           first 28 are checked, later ones only count for their end flag.
//   frame : one word per pulse flagged end_of_capture, carrying frame_ok,
//           command and toggle (command and toggle zero on failure).
//   cfg   : write channel for the tolerance in percent; always ready. Write
//           only while no capture is in flight.
// Throughput: one pulse word per cycle, except while an end-flagged word is held.
// Path: a pulse is taken into the input register and decoded from there; the
//   frame word of an end-flagged pulse is then held in the result register.
// Stalls: while the frame word waits, pulses without the end flag keep
//   flowing; a pulse with the end flag is held in the input register until
//   the result register frees, and pulse.ready drops behind it.
// Reset: frame state clears, tolerance returns to 40 percent; both channels
//   come up empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module rc5_half_bit_frame_decoder
#(
    parameter int DURATION_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    rc5hb_pulse_if.sink          pulse,
    rc5hb_frame_if.source        frame,
    rc5hb_cfg_if.sink            cfg
);
    import rc5hb_pkg::*;

    logic [TOL_W-1:0] tolerance_reg;

    pulse_t  in_pulse;
    pulse_t  stage_pulse;
    logic    stage_valid;
    logic    take;
    logic    slot_free;
    logic    res_valid;
    result_t result;
    result_t out_result;

    // Tolerance register: writes always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOLERANCE_RESET;
        end
        else if (cfg.valid)
        begin
            tolerance_reg <= cfg.tolerance_pct;
        end
    end

    assign in_pulse.is_mark        = pulse.is_mark;
    assign in_pulse.duration_us    = pulse.duration_us;
    assign in_pulse.end_of_capture = pulse.end_of_capture;

    // Input register
    rc5hb_pulse_stage u_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pulse.valid),
        .in_ready    (pulse.ready),
        .in_pulse    (in_pulse),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_pulse (stage_pulse)
    );

    // Checks, bit assembly and frame state
    rc5hb_decode
    #(
        .DURATION_BITS (DURATION_BITS)
    )
    u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_pulse (stage_pulse),
        .tolerance   (tolerance_reg),
        .slot_free   (slot_free),
        .take        (take),
        .res_valid   (res_valid),
        .result      (result)
    );

    // Result register
    rc5hb_result_reg u_result
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .result     (result),
        .slot_free  (slot_free),
        .out_valid  (frame.valid),
        .out_ready  (frame.ready),
        .out_result (out_result)
    );

    assign frame.frame_ok = out_result.frame_ok;
    assign frame.command  = out_result.command;
    assign frame.toggle   = out_result.toggle;
endmodule

>>> hdl/rc5hb_checker.sv
// ----------------------------------------------------------------------------
// rc5hb_checker
// Port-level assertions for the RC5 half-bit frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module rc5hb_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         in_eoc,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         out_ok,
    input  logic [rc5hb_pkg::CMD_W-1:0]  out_cmd,
    input  logic                         out_toggle
);
    import rc5hb_pkg::*;

    // Captures closed on the input side but not yet delivered.
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       eoc_in;
    logic       word_out;

    assign eoc_in   = in_valid && in_ready && in_eoc;
    assign word_out = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (eoc_in && !word_out)
            pending_next = pending_reg + 1'b1;
        else if (!eoc_in && word_out)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("frame word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_ok) && $stable(out_cmd) && $stable(out_toggle))
        else $error("frame word changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ok |-> (out_cmd == '0) && !out_toggle)
        else $error("failed frame carries command or toggle");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("frame word without a closed capture");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more closed captures in flight than the block holds");
endmodule

bind rc5_half_bit_frame_decoder rc5hb_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pulse.valid),
    .in_ready   (pulse.ready),
    .in_eoc     (pulse.end_of_capture),
    .out_valid  (frame.valid),
    .out_ready  (frame.ready),
    .out_ok     (frame.frame_ok),
    .out_cmd    (frame.command),
    .out_toggle (frame.toggle)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RC5 half-bit frame decoder: captures of pulse
// words go in, the frame words that come out are compared with a decoder
// kept in the bench, with random gaps on the pulse side and stalls on the
// frame side.
// ----------------------------------------------------------------------------
module tb;
    import rc5hb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PULSES = 600;
    localparam int NO_HALF       = -1;      // no half is disturbed

    logic clk = 1'b0;
    logic rst_n;

    rc5hb_pulse_if pulse_bus ();
    rc5hb_frame_if frame_bus ();
    rc5hb_cfg_if   cfg_bus ();

    rc5_half_bit_frame_decoder #(
        .DURATION_BITS (DURATION_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pulse (pulse_bus),
        .frame (frame_bus),
        .cfg   (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench copy of the decoder: register plus frame state.
    // ------------------------------------------------------------------------
    logic [TOL_W-1:0]      m_tol        = TOLERANCE_RESET;
    logic [HALF_W-1:0]     m_halves     = '0;
    logic [DURATION_W-1:0] m_ref_us     = '0;
    logic                  m_first_mark = 1'b0;
    logic                  m_failed     = 1'b0;
    logic                  m_toggle     = 1'b0;
    logic [CMD_W-1:0]      m_cmd        = '0;

    result_t frames_due[$];     // frame words still owed by the decoder
    int      mismatch_cnt = 0;
    int      pulses_sent  = 0;
    int      cycles       = 0;
    bit      steady       = 1'b0;   // both sides run without gaps while set

    // Fold one accepted pulse word into the frame state; an end-flagged word
    // closes the capture and queues the frame word it owes.
    task automatic decode_half(input pulse_t p);
        longint unsigned d;
        longint unsigned t;
        longint unsigned diff;
        logic [PAIR_W-1:0] pair_idx;
        logic decoded;
        result_t r;
        d = p.duration_us;
        if (m_halves < HALVES_PER_FRAME)
        begin
            if (m_halves == '0)
                m_ref_us = p.duration_us;
            t    = m_ref_us;
            diff = (d >= t) ? d - t : t - d;
            if (diff * 100 > t * longint'(m_tol))
                m_failed = 1'b1;
            // start bits: mark on even halves, space on odd ones
            if (m_halves < START_HALVES && p.is_mark != ~m_halves[0])
                m_failed = 1'b1;
            if (!m_halves[0])
                m_first_mark = p.is_mark;
            else
            begin
                pair_idx = m_halves[HALF_W-1:1];
                decoded  = m_first_mark & ~p.is_mark;
                if (pair_idx == TOGGLE_PAIR)
                    m_toggle = decoded;
                else if (pair_idx >= FIRST_CMD_PAIR)
                    m_cmd = {m_cmd[CMD_W-2:0], decoded};
            end
            m_halves = m_halves + 1'b1;
        end
        if (p.end_of_capture)
        begin
            r.frame_ok = !m_failed && (m_halves >= HALVES_PER_FRAME);
            r.command  = r.frame_ok ? m_cmd : '0;
            r.toggle   = r.frame_ok ? m_toggle : 1'b0;
            frames_due.push_back(r);
            m_halves     = '0;
            m_ref_us     = '0;
            m_first_mark = 1'b0;
            m_failed     = 1'b0;
            m_toggle     = 1'b0;
            m_cmd        = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Pulse side. valid is only lowered when a gap follows, so it never gets
    // two updates in one step.
    // ------------------------------------------------------------------------
    task automatic send_pulse(input logic mark, input logic [DURATION_W-1:0] dur,
                              input logic eoc);
        int unsigned gap;
        pulse_t p;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            pulse_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pulse_bus.valid          <= 1'b1;
        pulse_bus.is_mark        <= mark;
        pulse_bus.duration_us    <= dur;
        pulse_bus.end_of_capture <= eoc;
        do
            @(posedge clk);
        while (!pulse_bus.ready);
        p.is_mark        = mark;
        p.duration_us    = dur;
        p.end_of_capture = eoc;
        decode_half(p);
        pulses_sent++;
    endtask

    // One capture. Halves up to 28 follow the RC5 layout for payload
    // {toggle, address[4:0], command[5:0]} with durations jittered around
    // t_us; later pulses are random. bad_half gets the wrong level,
    // slow_half a duration just outside the current window. noise makes
    // every pulse random. The last pulse carries the end flag.
    task automatic send_capture(input logic [11:0] payload, input int unsigned t_us,
                                input int unsigned jit_pct, input int n_pulses,
                                input int bad_half, input int slow_half,
                                input bit noise);
        int unsigned span;
        int unsigned off;
        longint      dur;
        logic        mark;
        logic        code;
        for (int i = 0; i < n_pulses; i++)
        begin
            if (noise || i >= HALVES_PER_FRAME)
            begin
                mark = 1'($urandom_range(0, 1));
                dur  = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 2 * t_us);
            end
            else
            begin
                if (i < START_HALVES)
                    mark = (i % 2 == 0);
                else
                begin
                    code = payload[13 - (i >> 1)];
                    mark = (i % 2 == 0) ? code : ~code;
                end
                if (i == bad_half)
                    mark = ~mark;
                if (i == 0)
                    dur = t_us;
                else if (i == slow_half)
                begin
                    off = (t_us * m_tol) / 100 + 1;
                    dur = t_us + off;
                    if (dur > 65535)
                        dur = longint'(t_us) - off;
                end
                else
                begin
                    span = (t_us * jit_pct) / 100;
                    off  = $urandom_range(0, span);
                    if ($urandom_range(0, 3) == 0)
                        off = span + $urandom_range(0, 1);  // on the window edge
                    dur = $urandom_range(0, 1) ? longint'(t_us) + off
                                               : longint'(t_us) - off;
                end
            end
            if (dur < 0)
                dur = 0;
            if (dur > 65535)
                dur = 65535;
            send_pulse(mark, dur[DURATION_W-1:0], i == n_pulses - 1);
        end
    endtask

    // Hold the pulse side until every owed frame word is in, then let the
    // pipeline settle.
    task automatic await_frames();
        pulse_bus.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] pct);
        await_frames();
        cfg_bus.valid         <= 1'b1;
        cfg_bus.tolerance_pct <= pct;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        m_tol = pct;
    endtask

    // ------------------------------------------------------------------------
    // Frame side: random back-pressure, ready only dropped ahead of a stall.
    // ------------------------------------------------------------------------
    initial
    begin : frame_sink
        int unsigned stall;
        frame_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                frame_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            frame_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(frame_bus.valid && frame_bus.ready));
        end
    end

    // Each accepted frame word against the oldest owed one.
    always @(posedge clk)
    begin : frame_check
        result_t want;
        if (rst_n === 1'b1 && frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1)
        begin
            if (frames_due.size() == 0)
            begin
                $display("%0t: unexpected frame word ok=%b command=%0d toggle=%b",
                         $time, frame_bus.frame_ok, frame_bus.command, frame_bus.toggle);
                mismatch_cnt++;
            end
            else
            begin
                want = frames_due.pop_front();
                if (frame_bus.frame_ok !== want.frame_ok)
                begin
                    $display("%0t: frame_ok expected %b got %b",
                             $time, want.frame_ok, frame_bus.frame_ok);
                    mismatch_cnt++;
                end
                if (frame_bus.command !== want.command)
                begin
                    $display("%0t: command expected %0d got %0d",
                             $time, want.command, frame_bus.command);
                    mismatch_cnt++;
                end
                if (frame_bus.toggle !== want.toggle)
                begin
                    $display("%0t: toggle expected %b got %b",
                             $time, want.toggle, frame_bus.toggle);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[rc5_half_bit_frame_decoder] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Clean frame at the reset tolerance, jitter just inside 40 percent.
    task automatic test_default_tolerance();
        send_capture(12'hA5C, 889, 35, 28, NO_HALF, NO_HALF, 1'b0);
    endtask

    // Captures closed early: a lone pulse and the start halves followed by one more.
    task automatic test_short_capture();
        send_capture(12'h000, 889, 0, 1, NO_HALF, NO_HALF, 1'b0);
        send_capture(12'hFFF, 889, 0, 5, NO_HALF, NO_HALF, 1'b0);
    endtask

    // All-ones payload at full-scale durations with trailing pulses, then
    // all-zeros at the smallest non-zero reference; no gaps on either side.
    task automatic test_extreme_frame();
        steady = 1'b1;
        send_capture(12'hFFF, 65535, 40, 31, NO_HALF, NO_HALF, 1'b0);
        send_capture(12'h000, 1, 0, 28, NO_HALF, NO_HALF, 1'b0);
        steady = 1'b0;
    endtask

    // Zero reference: only zero-length halves pass.
    task automatic test_zero_reference();
        send_capture(12'($urandom_range(0, 4095)), 0, 0, 28, NO_HALF, NO_HALF, 1'b0);
        send_capture(12'($urandom_range(0, 4095)), 0, 0, 28, NO_HALF, 20, 1'b0);
    endtask

    // Wrong level in one of the start halves.
    task automatic test_start_bits();
        send_capture(12'($urandom_range(0, 4095)), 889, 10, 28,
                     $urandom_range(0, 3), NO_HALF, 1'b0);
    endtask

    // Register extremes, including values above 100.
    task automatic test_tolerance_extremes();
        write_tolerance(7'd0);
        send_capture(12'($urandom_range(0, 4095)), 889, 0, 28, NO_HALF, NO_HALF, 1'b0);
        send_capture(12'($urandom_range(0, 4095)), 889, 0, 28, NO_HALF, 13, 1'b0);
        write_tolerance(PCT_SCALE);
        send_capture(12'($urandom_range(0, 4095)), 889, 100, 28, NO_HALF, NO_HALF, 1'b0);
        write_tolerance(7'd127);
        send_capture(12'($urandom_range(0, 4095)), 1200, 127, 29, NO_HALF, 27, 1'b0);
    endtask

    // Mostly well-formed captures with random content, the rest broken or
    // noise; the tolerance is rewritten now and then between captures.
    task automatic test_random_traffic();
        int start_cnt;
        int kind;
        int unsigned t_us;
        logic [TOL_W-1:0] pct;
        start_cnt = pulses_sent;
        while (pulses_sent - start_cnt < RANDOM_PULSES)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       pct = 7'd0;
                    1:       pct = PCT_SCALE;
                    2:       pct = 7'd127;
                    default: pct = 7'($urandom_range(0, 127));
                endcase
                write_tolerance(pct);
            end
            steady = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1:    t_us = $urandom_range(0, 65535);
                2:       t_us = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 1);
                default: t_us = $urandom_range(400, 2000);
            endcase
            kind = $urandom_range(0, 99);
            if (kind < 60)
                send_capture(12'($urandom_range(0, 4095)), t_us, $urandom_range(0, m_tol),
                             28 + $urandom_range(0, 3), NO_HALF, NO_HALF, 1'b0);
            else if (kind < 75)
                send_capture(12'($urandom_range(0, 4095)), t_us,
                             m_tol + $urandom_range(0, 10),
                             28 + $urandom_range(0, 2), NO_HALF,
                             $urandom_range(0, 3) == 0 ? $urandom_range(1, 27) : NO_HALF,
                             1'b0);
            else if (kind < 85)
                send_capture(12'($urandom_range(0, 4095)), t_us, $urandom_range(0, m_tol),
                             28, $urandom_range(0, 3), NO_HALF, 1'b0);
            else if (kind < 93)
                send_capture(12'($urandom_range(0, 4095)), t_us, $urandom_range(0, m_tol),
                             $urandom_range(1, 27), NO_HALF, NO_HALF, 1'b0);
            else
                send_capture(12'h000, t_us, 0, $urandom_range(1, 40),
                             NO_HALF, NO_HALF, 1'b1);
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                    <= 1'b0;
        pulse_bus.valid          <= 1'b0;
        pulse_bus.is_mark        <= 1'b0;
        pulse_bus.duration_us    <= '0;
        pulse_bus.end_of_capture <= 1'b0;
        cfg_bus.valid            <= 1'b0;
        cfg_bus.tolerance_pct    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_tolerance();
        test_short_capture();
        test_extreme_frame();
        test_zero_reference();
        test_start_bits();
        test_tolerance_extremes();
        test_random_traffic();

        await_frames();
        if (mismatch_cnt == 0)
            $display("[rc5_half_bit_frame_decoder] OK");
        else
            $display("[rc5_half_bit_frame_decoder] ERROR");
        $finish;
    end

endmodule
